[rtl/assert_macros.svh]
// Assertion helpers shared by the design files.
// All checks sample on the rising edge of clock and are held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TSBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define TSBS_ASSERT_IMPLIES(label, ante, cons, msg) \
   `TSBS_ASSERT(label, (ante) |-> (cons), msg)

`endif

[rtl/tsbs_pkg.sv]
`default_nettype none

package tsbs_pkg;

   // Item kinds carried on the request channel.
   typedef enum logic [1:0] {
      ACT_TICK     = 2'd0,
      ACT_RESPONSE = 2'd1,
      ACT_RESTART  = 2'd2
   } action_type;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_BURST_LENGTH   = 2'd0;
   localparam logic [1:0] REG_BURST_GAP      = 2'd1;
   localparam logic [1:0] REG_REPLY_TIMEOUT  = 2'd2;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Reset values of the registers.
   localparam logic [7:0]  BURST_LENGTH_RESET  = 8'd8;
   localparam logic [31:0] BURST_GAP_RESET     = 32'd10000;
   localparam logic [31:0] REPLY_TIMEOUT_RESET = 32'd1000;

   // Saturation limit of the request counter; it also marks a finished burst.
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // Number of positive replies that end the first burst.
   localparam logic [1:0] FIRST_BURST_REPLIES = 2'd2;
   localparam logic [1:0] FIRST_COUNT_MAX     = 2'd3;

   typedef struct packed {
      logic [7:0]  burst_length;
      logic [31:0] burst_gap_ms;
      logic [31:0] reply_timeout_ms;
   } cfg_type;

   typedef struct packed {
      action_type         action;
      logic [47:0]        now_ms;
      logic               link_ready;
      logic               send_accepted;
      logic signed [47:0] sample_offset;
      logic signed [47:0] sample_error;
      logic [47:0]        sample_time;
   } item_type;

   typedef struct packed {
      logic               request_sent;
      logic               burst_done;
      logic               update_valid;
      logic signed [47:0] update_offset;
      logic [46:0]        update_error;
      logic [47:0]        update_time;
   } result_type;

endpackage

`default_nettype wire

[rtl/time_sync_burst_scheduler_top.sv]
// Time sync burst scheduler.
// Request channel (req_*): one beat per event: a tick carrying the current
// millisecond time and link status, a sync response carrying offset, error
// bound and timestamp, or a restart. Every accepted beat yields exactly one
// beat on the result channel (rsp_*), in order.
// Configuration is written over the csr_* APB-style port while the block is
// idle: burst length at 0x0, burst gap at 0x4, reply timeout at 0x8.
// An accepted beat is held in the input register and then moves to the result
// register, whose output drives the result channel and rsp_valid.
// Throughput: one beat per cycle while results are taken, set by the single
// step of compares and subtracts between the input and result registers.
// A stalled receiver holds the result register; the input register still
// takes one more beat, and then req_ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers, loads the
// register defaults and arms the scheduler so the first tick starts a burst.
`default_nettype none
`include "assert_macros.svh"

module time_sync_burst_scheduler_top
   import tsbs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_action,
   input  wire logic [47:0]               req_now_ms,
   input  wire logic                      req_link_ready,
   input  wire logic                      req_send_accepted,
   input  wire logic signed [47:0]        req_sample_offset,
   input  wire logic signed [47:0]        req_sample_error,
   input  wire logic [47:0]               req_sample_time,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_request_sent,
   output logic                           rsp_burst_done,
   output logic                           rsp_update_valid,
   output logic signed [47:0]             rsp_update_offset,
   output logic [46:0]                    rsp_update_error,
   output logic [47:0]                    rsp_update_time,

   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   cfg_type    cfg;
   item_type   req_item;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_take;

   // Configuration registers.
   tsbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Gather the request beat.
   assign req_item.action        = action_type'(req_action);
   assign req_item.now_ms        = req_now_ms;
   assign req_item.link_ready    = req_link_ready;
   assign req_item.send_accepted = req_send_accepted;
   assign req_item.sample_offset = req_sample_offset;
   assign req_item.sample_error  = req_sample_error;
   assign req_item.sample_time   = req_sample_time;

   // Pipeline flow control: the result register frees when empty or taken.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !item_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // Input register.
   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_in       = req_item;
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   // Scheduler state and step logic.
   tsbs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (item_valid_ff && advance),
      .item    (item_ff),
      .result  (result)
   );

   // Result register.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = result;
         rsp_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_request_sent  = rsp_ff.request_sent;
   assign rsp_burst_done    = rsp_ff.burst_done;
   assign rsp_update_valid  = rsp_ff.update_valid;
   assign rsp_update_offset = rsp_ff.update_offset;
   assign rsp_update_error  = rsp_ff.update_error;
   assign rsp_update_time   = rsp_ff.update_time;

   // An emitted update always carries a positive error bound.
   `TSBS_ASSERT_IMPLIES(a_update_error_positive, rsp_valid && rsp_update_valid, rsp_update_error != '0, "update with zero error bound")

   // Without an update the update fields stay zero.
   `TSBS_ASSERT_IMPLIES(a_update_fields_clear, rsp_valid && !rsp_update_valid, (rsp_update_offset == '0) && (rsp_update_error == '0) && (rsp_update_time == '0), "update fields set without update")

   // A request is only sent on a tick that emits no update.
   `TSBS_ASSERT(a_send_without_update, !(rsp_valid && rsp_request_sent && rsp_update_valid), "request sent together with an update")

endmodule

`default_nettype wire

[rtl/tsbs_csr.sv]
`default_nettype none

module tsbs_csr
   import tsbs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output cfg_type                        cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // Register write decode; addresses past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_BURST_LENGTH:  cfg_in.burst_length     = csr_pwdata[7:0];
            REG_BURST_GAP:     cfg_in.burst_gap_ms     = csr_pwdata;
            REG_REPLY_TIMEOUT: cfg_in.reply_timeout_ms = csr_pwdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_length     <= BURST_LENGTH_RESET;
         cfg_ff.burst_gap_ms     <= BURST_GAP_RESET;
         cfg_ff.reply_timeout_ms <= REPLY_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (reg_index)
         REG_BURST_LENGTH:  csr_prdata = {24'd0, cfg_ff.burst_length};
         REG_BURST_GAP:     csr_prdata = cfg_ff.burst_gap_ms;
         REG_REPLY_TIMEOUT: csr_prdata = cfg_ff.reply_timeout_ms;
         default:           csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/tsbs_core.sv]
`default_nettype none

module tsbs_core
   import tsbs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       step_en,
   input  wire item_type   item,
   output result_type     result
);

   // Scheduler state.
   logic [7:0]  count_ff, count_in;
   logic        await_ff, await_in;
   logic [47:0] end_time_ff, end_time_in;
   logic [47:0] req_time_ff, req_time_in;
   logic        pend_ff, pend_in;
   logic        first_ff, first_in;
   logic [1:0]  first_cnt_ff, first_cnt_in;
   logic        best_ok_ff, best_ok_in;
   logic [46:0] best_err_ff, best_err_in;
   logic [47:0] best_off_ff, best_off_in;
   logic [47:0] best_time_ff, best_time_in;

   // Shared arithmetic.
   logic [47:0] since_end;
   logic [47:0] since_req;
   logic        count_full;
   logic        gap_open;
   logic        timed_out;
   logic [7:0]  tick_count;
   logic [7:0]  tick_count_inc;
   logic [7:0]  rsp_count_inc;
   logic        positive;
   logic        better;
   logic        best_ok_new;
   logic [46:0] best_err_new;
   logic [47:0] best_off_new;
   logic [47:0] best_time_new;
   logic [1:0]  first_cnt_inc;
   logic        first_done;

   assign since_end  = item.now_ms - end_time_ff;
   assign since_req  = item.now_ms - req_time_ff;
   assign count_full = count_ff >= cfg.burst_length;
   assign gap_open   = since_end >= {16'd0, cfg.burst_gap_ms};
   assign timed_out  = since_req > {16'd0, cfg.reply_timeout_ms};

   // A tick that opens a new burst starts counting from zero.
   assign tick_count     = count_full ? 8'd0 : count_ff;
   assign tick_count_inc = (tick_count == COUNT_MAX) ? COUNT_MAX : tick_count + 8'd1;
   assign rsp_count_inc  = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 8'd1;

   // Best sample tracking on a response beat.
   assign positive      = !item.sample_error[47] && (item.sample_error != '0);
   assign better        = positive && (!best_ok_ff || (item.sample_error[46:0] < best_err_ff));
   assign best_ok_new   = best_ok_ff || better;
   assign best_err_new  = better ? item.sample_error[46:0] : best_err_ff;
   assign best_off_new  = better ? item.sample_offset : best_off_ff;
   assign best_time_new = better ? item.sample_time : best_time_ff;

   assign first_cnt_inc = (first_cnt_ff == FIRST_COUNT_MAX) ? FIRST_COUNT_MAX
                                                            : first_cnt_ff + 2'd1;
   assign first_done    = first_ff && positive && (first_cnt_inc >= FIRST_BURST_REPLIES);

   // Next state and result for one beat.
   always_comb begin
      count_in     = count_ff;
      await_in     = await_ff;
      end_time_in  = end_time_ff;
      req_time_in  = req_time_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      first_cnt_in = first_cnt_ff;
      best_ok_in   = best_ok_ff;
      best_err_in  = best_err_ff;
      best_off_in  = best_off_ff;
      best_time_in = best_time_ff;
      result       = '0;

      if (step_en) begin
         unique case (item.action)
            ACT_TICK: begin
               // A completion seen on a response is reported once more here.
               result.burst_done = pend_ff;
               pend_in           = 1'b0;
               if (item.link_ready && (!count_full || gap_open)) begin
                  count_in = tick_count;
                  if (count_full) begin
                     best_ok_in = 1'b0;
                  end
                  if (await_ff) begin
                     if (timed_out) begin
                        await_in = 1'b0;
                        count_in = tick_count_inc;
                        if (tick_count_inc >= cfg.burst_length) begin
                           if (best_ok_ff && !count_full) begin
                              result.update_valid  = 1'b1;
                              result.update_offset = best_off_ff;
                              result.update_error  = best_err_ff;
                              result.update_time   = best_time_ff;
                           end
                           end_time_in       = item.now_ms;
                           result.burst_done = 1'b1;
                        end
                     end
                  end else if (item.send_accepted) begin
                     await_in            = 1'b1;
                     req_time_in         = item.now_ms;
                     result.request_sent = 1'b1;
                  end
               end
            end

            ACT_RESPONSE: begin
               best_ok_in   = best_ok_new;
               best_err_in  = best_err_new;
               best_off_in  = best_off_new;
               best_time_in = best_time_new;
               await_in     = 1'b0;
               count_in     = rsp_count_inc;
               // During the first burst every positive reply goes out at once.
               if (first_ff && positive) begin
                  result.update_valid  = 1'b1;
                  result.update_offset = item.sample_offset;
                  result.update_error  = item.sample_error[46:0];
                  result.update_time   = item.sample_time;
                  first_cnt_in         = first_cnt_inc;
               end
               if (first_done) begin
                  count_in          = cfg.burst_length;
                  end_time_in       = item.now_ms;
                  pend_in           = 1'b1;
                  first_in          = 1'b0;
                  result.burst_done = 1'b1;
               end else if (rsp_count_inc >= cfg.burst_length) begin
                  if (best_ok_new) begin
                     if (!(first_ff && positive)) begin
                        result.update_valid  = 1'b1;
                        result.update_offset = best_off_new;
                        result.update_error  = best_err_new;
                        result.update_time   = best_time_new;
                     end
                     first_in = 1'b0;
                  end
                  end_time_in       = item.now_ms;
                  pend_in           = 1'b1;
                  result.burst_done = 1'b1;
               end
            end

            ACT_RESTART: begin
               count_in     = COUNT_MAX;
               await_in     = 1'b0;
               end_time_in  = item.now_ms - {16'd0, cfg.burst_gap_ms};
               req_time_in  = '0;
               pend_in      = 1'b0;
               first_in     = 1'b1;
               first_cnt_in = '0;
               best_ok_in   = 1'b0;
               best_err_in  = '0;
               best_off_in  = '0;
               best_time_in = '0;
            end

            default: begin
               result = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_MAX;
         await_ff     <= 1'b0;
         end_time_ff  <= 48'd0 - {16'd0, BURST_GAP_RESET};
         req_time_ff  <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b1;
         first_cnt_ff <= '0;
         best_ok_ff   <= 1'b0;
         best_err_ff  <= '0;
         best_off_ff  <= '0;
         best_time_ff <= '0;
      end else begin
         count_ff     <= count_in;
         await_ff     <= await_in;
         end_time_ff  <= end_time_in;
         req_time_ff  <= req_time_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         first_cnt_ff <= first_cnt_in;
         best_ok_ff   <= best_ok_in;
         best_err_ff  <= best_err_in;
         best_off_ff  <= best_off_in;
         best_time_ff <= best_time_in;
      end
   end

endmodule

`default_nettype wire

[verif/burst_sched_checker.sv]
module burst_sched_checker
   import tsbs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic [1:0]                req_action,
   input  wire logic [47:0]               req_now_ms,
   input  wire logic                      req_link_ready,
   input  wire logic                      req_send_accepted,
   input  wire logic [47:0]               req_sample_offset,
   input  wire logic [47:0]               req_sample_error,
   input  wire logic [47:0]               req_sample_time,

   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic                      rsp_request_sent,
   input  wire logic                      rsp_burst_done,
   input  wire logic                      rsp_update_valid,
   input  wire logic [47:0]               rsp_update_offset,
   input  wire logic [46:0]               rsp_update_error,
   input  wire logic [47:0]               rsp_update_time,

   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  wire logic                      csr_pready,

   output logic [31:0]                    fail_count,
   output logic [31:0]                    open_count
);

   // Copies of the registers, followed from the configuration port.
   logic [7:0]  len_cfg;
   logic [31:0] gap_cfg;
   logic [31:0] timeout_cfg;

   // Scheduler state as the block should hold it.
   logic [7:0]  reply_count;
   logic        waiting;
   logic [47:0] burst_end_ms;
   logic [47:0] sent_ms;
   logic        done_pending;
   logic        in_first_burst;
   logic [1:0]  first_replies;
   logic        have_best;
   logic [46:0] best_err;
   logic [47:0] best_off;
   logic [47:0] best_ts;

   // Result beats predicted but not yet seen, oldest first.
   result_type due_results[$];

   // Arms the scheduler so that a tick from now on starts a burst.
   task rearm_at(input logic [47:0] now);
      reply_count    = COUNT_MAX;
      waiting        = 1'b0;
      burst_end_ms   = now - {16'd0, gap_cfg};
      sent_ms        = '0;
      done_pending   = 1'b0;
      in_first_burst = 1'b1;
      first_replies  = '0;
      have_best      = 1'b0;
      best_err       = '0;
      best_off       = '0;
      best_ts        = '0;
   endtask

   // The request counter saturates instead of wrapping.
   task count_reply();
      if (reply_count < COUNT_MAX)
         reply_count = reply_count + 8'd1;
   endtask

   task emit_best(inout result_type res);
      res.update_valid  = 1'b1;
      res.update_offset = best_off;
      res.update_error  = best_err;
      res.update_time   = best_ts;
   endtask

   // Advances the scheduler by one request beat and gives its result beat.
   task predict_schedule(input logic [1:0] act, input logic [47:0] now,
                         input logic link, input logic accepted,
                         input logic [47:0] off, input logic [47:0] err,
                         input logic [47:0] ts, output result_type res);
      logic [47:0] elapsed;
      logic        positive;
      logic        go_on;
      logic        first_done;
      res = '0;
      case (act)
         ACT_TICK: begin
            // A completion left by a response is reported on the next tick.
            res.burst_done = done_pending;
            done_pending = 1'b0;
            if (link) begin
               go_on = 1'b1;
               if (reply_count >= len_cfg) begin
                  elapsed = now - burst_end_ms;
                  if (elapsed < {16'd0, gap_cfg}) begin
                     go_on = 1'b0;
                  end else begin
                     reply_count = '0;
                     have_best = 1'b0;
                  end
               end
               if (go_on) begin
                  if (waiting) begin
                     // An outstanding request may time out and close the burst.
                     elapsed = now - sent_ms;
                     if (elapsed > {16'd0, timeout_cfg}) begin
                        waiting = 1'b0;
                        count_reply();
                        if (reply_count >= len_cfg) begin
                           if (have_best)
                              emit_best(res);
                           burst_end_ms = now;
                           res.burst_done = 1'b1;
                        end
                     end
                  end else if (accepted) begin
                     waiting = 1'b1;
                     sent_ms = now;
                     res.request_sent = 1'b1;
                  end
               end
            end
         end
         ACT_RESPONSE: begin
            positive = !err[47] && (err != '0);
            // Keep the sample with the smallest positive error bound.
            if (positive && (!have_best || err[46:0] < best_err)) begin
               have_best = 1'b1;
               best_err  = err[46:0];
               best_off  = off;
               best_ts   = ts;
            end
            waiting = 1'b0;
            count_reply();
            first_done = 1'b0;
            // In the first burst every positive reply is passed on at once.
            if (in_first_burst && positive) begin
               res.update_valid  = 1'b1;
               res.update_offset = off;
               res.update_error  = err[46:0];
               res.update_time   = ts;
               if (first_replies < FIRST_COUNT_MAX)
                  first_replies = first_replies + 2'd1;
               if (first_replies >= FIRST_BURST_REPLIES) begin
                  reply_count    = len_cfg;
                  burst_end_ms   = now;
                  done_pending   = 1'b1;
                  in_first_burst = 1'b0;
                  res.burst_done = 1'b1;
                  first_done     = 1'b1;
               end
            end
            if (!first_done && reply_count >= len_cfg) begin
               if (have_best) begin
                  if (!res.update_valid)
                     emit_best(res);
                  in_first_burst = 1'b0;
               end
               burst_end_ms   = now;
               done_pending   = 1'b1;
               res.burst_done = 1'b1;
            end
         end
         ACT_RESTART: begin
            rearm_at(now);
         end
         default: begin
            // The unused code leaves everything alone.
         end
      endcase
   endtask

   task report_mismatch(input string what, input logic [47:0] got, input logic [47:0] want);
      fail_count = fail_count + 1;
      $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
   endtask

   // All sampling happens at the rising edge, on values from before the edge.
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         len_cfg     = BURST_LENGTH_RESET;
         gap_cfg     = BURST_GAP_RESET;
         timeout_cfg = REPLY_TIMEOUT_RESET;
         rearm_at('0);
         due_results.delete();
         fail_count = '0;
         open_count <= '0;
      end else begin
         // A register is written at the access-phase edge.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_BURST_LENGTH:  len_cfg = csr_pwdata[7:0];
               REG_BURST_GAP:     gap_cfg = csr_pwdata;
               REG_REPLY_TIMEOUT: timeout_cfg = csr_pwdata;
               default: ;
            endcase
         end

         // Each result beat is held against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected result beat", '0, '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_request_sent !== want.request_sent)
                  report_mismatch("request_sent", {47'd0, rsp_request_sent},
                                  {47'd0, want.request_sent});
               if (rsp_burst_done !== want.burst_done)
                  report_mismatch("burst_done", {47'd0, rsp_burst_done},
                                  {47'd0, want.burst_done});
               if (rsp_update_valid !== want.update_valid)
                  report_mismatch("update_valid", {47'd0, rsp_update_valid},
                                  {47'd0, want.update_valid});
               if (rsp_update_offset !== want.update_offset)
                  report_mismatch("update_offset", rsp_update_offset, want.update_offset);
               if (rsp_update_error !== want.update_error)
                  report_mismatch("update_error", {1'b0, rsp_update_error},
                                  {1'b0, want.update_error});
               if (rsp_update_time !== want.update_time)
                  report_mismatch("update_time", rsp_update_time, want.update_time);
            end
         end

         // Every accepted request beat yields one predicted result beat.
         if (req_valid && req_ready) begin
            predict_schedule(req_action, req_now_ms, req_link_ready, req_send_accepted,
                             req_sample_offset, req_sample_error, req_sample_time, want);
            due_results.push_back(want);
         end
         open_count <= due_results.size();
      end
   end

endmodule

[verif/tb.sv]
module tb;
   import tsbs_pkg::*;

   localparam logic [1:0]  ACT_UNUSED = 2'd3;
   localparam logic [47:0] ALL_ONES   = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] MAX_POS    = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] MIN_NEG    = 48'h8000_0000_0000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_action = ACT_TICK;
   logic [47:0]               req_now_ms = '0;
   logic                      req_link_ready = 1'b0;
   logic                      req_send_accepted = 1'b0;
   logic [47:0]               req_sample_offset = '0;
   logic [47:0]               req_sample_error = '0;
   logic [47:0]               req_sample_time = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_request_sent;
   logic                      rsp_burst_done;
   logic                      rsp_update_valid;
   logic [47:0]               rsp_update_offset;
   logic [46:0]               rsp_update_error;
   logic [47:0]               rsp_update_time;

   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   logic [31:0]               fail_count;
   logic [31:0]               open_count;

   // Stimulus bookkeeping.
   logic [47:0]               now_ms_cur = '0;
   logic [31:0]               gap_cur = BURST_GAP_RESET;
   logic [31:0]               timeout_cur = REPLY_TIMEOUT_RESET;
   int                        beats_sent = 0;
   int                        settings_used = 1;
   int                        hold_asked = 0;
   logic                      sender_idles = 1'b1;
   logic                      receiver_idles = 1'b1;

   always #5 clock = ~clock;

   time_sync_burst_scheduler_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_now_ms        (req_now_ms),
      .req_link_ready    (req_link_ready),
      .req_send_accepted (req_send_accepted),
      .req_sample_offset (req_sample_offset),
      .req_sample_error  (req_sample_error),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_request_sent  (rsp_request_sent),
      .rsp_burst_done    (rsp_burst_done),
      .rsp_update_valid  (rsp_update_valid),
      .rsp_update_offset (rsp_update_offset),
      .rsp_update_error  (rsp_update_error),
      .rsp_update_time   (rsp_update_time),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   burst_sched_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_now_ms        (req_now_ms),
      .req_link_ready    (req_link_ready),
      .req_send_accepted (req_send_accepted),
      .req_sample_offset (req_sample_offset),
      .req_sample_error  (req_sample_error),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_request_sent  (rsp_request_sent),
      .rsp_burst_done    (rsp_burst_done),
      .rsp_update_valid  (rsp_update_valid),
      .rsp_update_offset (rsp_update_offset),
      .rsp_update_error  (rsp_update_error),
      .rsp_update_time   (rsp_update_time),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .open_count        (open_count)
   );

   function automatic logic [47:0] rand48();
      logic [31:0] lo;
      logic [15:0] hi;
      lo = $urandom;
      hi = lo[15:0];
      lo = $urandom;
      return {hi, lo};
   endfunction

   // Error bounds lean to small positive values so that the best-sample
   // search has real competition, with zero, negative and extreme values mixed in.
   function automatic logic [47:0] pick_error();
      logic [31:0] pick;
      logic [31:0] mag;
      pick = $urandom_range(0, 9);
      mag = $urandom_range(1, 1000);
      case (pick)
         0: return '0;
         1: return rand48() | MIN_NEG;
         2: return rand48();
         3: return MAX_POS;
         4: return 48'd1;
         default: return {16'd0, mag};
      endcase
   endfunction

   // Offers one request beat and returns at the edge where it is accepted.
   task automatic send_beat(input logic [1:0] act, input logic [47:0] now,
                            input logic link, input logic accepted,
                            input logic [47:0] off, input logic [47:0] err,
                            input logic [47:0] ts);
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_now_ms        <= now;
      req_link_ready    <= link;
      req_send_accepted <= accepted;
      req_sample_offset <= off;
      req_sample_error  <= err;
      req_sample_time   <= ts;
      do @(posedge clock); while (!req_ready);
      if (act != ACT_UNUSED)
         beats_sent++;
   endtask

   // Stops offering beats and waits until every predicted result has arrived.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // New register settings are applied only once the block has gone idle.
   task automatic apply_settings(input logic [7:0] len, input logic [31:0] gap,
                                 input logic [31:0] timeout);
      wait_results_drained();
      write_reg(REG_BURST_LENGTH, {24'd0, len});
      write_reg(REG_BURST_GAP, gap);
      write_reg(REG_REPLY_TIMEOUT, timeout);
      gap_cur = gap;
      timeout_cur = timeout;
      settings_used++;
   endtask

   // Mostly request and reply pairs with random content; the rest is time
   // jumps past the timeout or the gap, stray replies, restarts and noise.
   task automatic run_random(input int count);
      int          stop_at;
      logic [31:0] pick;
      logic [31:0] step;
      logic [31:0] bits;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         step = $urandom_range(0, 3);
         bits = $urandom;
         now_ms_cur = now_ms_cur + {16'd0, step};
         if (pick < 50) begin
            send_beat(ACT_TICK, now_ms_cur, 1'b1, 1'b1, rand48(), rand48(), rand48());
            now_ms_cur = now_ms_cur + {16'd0, step};
            send_beat(ACT_RESPONSE, now_ms_cur, bits[0], bits[1], rand48(), pick_error(),
                      rand48());
         end else if (pick < 62) begin
            send_beat(ACT_TICK, now_ms_cur, bits[0] | bits[1], bits[2], rand48(), rand48(),
                      rand48());
         end else if (pick < 70) begin
            now_ms_cur = now_ms_cur + {16'd0, timeout_cur} + 48'd1;
            send_beat(ACT_TICK, now_ms_cur, 1'b1, bits[0], rand48(), rand48(), rand48());
         end else if (pick < 76) begin
            now_ms_cur = now_ms_cur + {16'd0, gap_cur};
            send_beat(ACT_TICK, now_ms_cur, 1'b1, 1'b1, rand48(), rand48(), rand48());
         end else if (pick < 84) begin
            send_beat(ACT_RESPONSE, now_ms_cur, bits[0], bits[1], rand48(), pick_error(),
                      rand48());
         end else if (pick < 87) begin
            send_beat(ACT_RESTART, now_ms_cur, bits[0], bits[1], rand48(), rand48(),
                      rand48());
         end else if (pick < 91) begin
            now_ms_cur = rand48();
            send_beat(ACT_TICK, now_ms_cur, 1'b1, 1'b1, rand48(), rand48(), rand48());
         end else if (pick < 93) begin
            send_beat(ACT_UNUSED, rand48(), bits[0], bits[1], rand48(), rand48(), rand48());
         end else begin
            send_beat(ACT_TICK, now_ms_cur, 1'b0, bits[0], rand48(), rand48(), rand48());
         end
      end
   endtask

   // The receiver stalls in short random bursts, and for one long stretch
   // each time the stimulus asks for it.
   initial begin : receiver
      int stall_left;
      int holds_seen;
      stall_left = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (holds_seen != hold_asked) begin
            holds_seen = hold_asked;
            stall_left = 299;
            rsp_ready <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings.
      send_beat(ACT_UNUSED, ALL_ONES, 1'b1, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
      // A reply before any request: the counter stays saturated and the burst closes.
      send_beat(ACT_RESPONSE, 48'd0, 1'b0, 1'b0, '0, MIN_NEG, '0);
      send_beat(ACT_TICK, 48'd5, 1'b0, 1'b1, '0, '0, '0);
      send_beat(ACT_TICK, 48'd10000, 1'b1, 1'b1, '0, '0, '0);
      send_beat(ACT_RESPONSE, 48'd10001, 1'b0, 1'b0, 48'd7, 48'd0, 48'd9);
      send_beat(ACT_TICK, 48'd10002, 1'b1, 1'b0, '0, '0, '0);
      send_beat(ACT_TICK, 48'd10003, 1'b1, 1'b1, '0, '0, '0);
      // Exactly at the timeout, then just past it.
      send_beat(ACT_TICK, 48'd11003, 1'b1, 1'b1, '0, '0, '0);
      send_beat(ACT_TICK, 48'd11004, 1'b1, 1'b1, '0, '0, '0);
      send_beat(ACT_TICK, 48'd11005, 1'b1, 1'b1, '0, '0, '0);
      send_beat(ACT_RESPONSE, 48'd11005, 1'b1, 1'b1, MIN_NEG, MAX_POS, ALL_ONES);
      send_beat(ACT_TICK, 48'd11006, 1'b1, 1'b1, '0, '0, '0);
      // Second positive reply ends the first burst.
      send_beat(ACT_RESPONSE, 48'd11006, 1'b0, 1'b0, MAX_POS, 48'd1, 48'd0);
      send_beat(ACT_TICK, 48'd11007, 1'b1, 1'b1, '0, '0, '0);
      // Time running backwards counts as a long wait.
      send_beat(ACT_TICK, 48'd0, 1'b1, 1'b1, '0, '0, '0);
      send_beat(ACT_RESPONSE, 48'd1, 1'b0, 1'b0, 48'd11, 48'd300, 48'd12);
      send_beat(ACT_RESPONSE, 48'd2, 1'b0, 1'b0, 48'd13, 48'd200, 48'd14);
      send_beat(ACT_RESTART, ALL_ONES, 1'b0, 1'b0, '0, '0, '0);
      // Wraps past the top of the time range to exactly one gap later.
      send_beat(ACT_TICK, 48'd9999, 1'b1, 1'b1, '0, '0, '0);
      send_beat(ACT_RESPONSE, 48'd10000, 1'b0, 1'b0, ALL_ONES, 48'd5, ALL_ONES);
      send_beat(ACT_RESTART, 48'd0, 1'b1, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
      now_ms_cur = 48'd20000;

      apply_settings(8'd4, 32'd20, 32'd10);
      run_random(300);
      apply_settings(8'd1, 32'd0, 32'd0);
      run_random(250);
      apply_settings(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(250);
      // A zero burst length closes the burst on every reply.
      apply_settings(8'd0, 32'd5, 32'd3);
      run_random(200);

      // Back-pressure: the receiver holds off while the sender keeps offering.
      apply_settings(8'd6, 32'd30, 32'd15);
      run_random(150);
      hold_asked++;
      sender_idles = 1'b0;
      run_random(60);
      sender_idles = 1'b1;
      wait_results_drained();
      run_random(150);

      // Last part runs with neither side idling.
      apply_settings(8'd3, 32'd8, 32'd4);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      run_random(300);

      wait_results_drained();
      repeat (10) @(posedge clock);
      $display("Sent %0d request beats under %0d register settings, with timeouts, restarts,",
               beats_sent, settings_used);
      $display("backward time, stray replies and a long result stall.");
      if (fail_count == 0 && open_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
